@@ sv/mi3_pkg.sv @@
package mi3_pkg;

  localparam int Lanes = 9;
  localparam int ElemW = 32;
  localparam int ProdW = 64;
  localparam int LoW   = 65;
  localparam int DetW  = 98;
  localparam int AdW   = 97;
  localparam int QW    = 32;
  localparam int ShiftW = 32;

  typedef logic signed [ElemW-1:0] elem_t;
  typedef logic signed [ProdW-1:0] prod_t;
  typedef logic signed [LoW-1:0]   plo_t;
  typedef logic signed [DetW-1:0]  det_t;
  typedef logic [AdW-1:0]          mag_t;

  // classified word between front and back
  typedef struct packed {
    logic                        sing;
    mag_t                        ad;
    logic [Lanes-1:0][ProdW-1:0] m;
    logic [Lanes-1:0]            neg;
    logic [Lanes-1:0]            ovf;
  } job_t;

  typedef struct packed {
    logic                      sing;
    mag_t                      ad;
    logic [Lanes-1:0][AdW-1:0] rem;
    logic [Lanes-1:0][QW-1:0]  q;
    logic [Lanes-1:0]          neg;
    logic [Lanes-1:0]          ovf;
  } divst_t;

  typedef struct packed {
    logic [Lanes-1:0][ElemW-1:0] elem;
    logic                        sing;
    logic                        sat;
  } res_t;

  localparam logic [ElemW-1:0] PosMax = {1'b0, {(ElemW-1){1'b1}}};
  localparam logic [ElemW-1:0] NegMin = {1'b1, {(ElemW-1){1'b0}}};

  function automatic prod_t mul_ss(elem_t a, elem_t b);
    return ProdW'(a) * ProdW'(b);
  endfunction

  function automatic plo_t mul_lo(elem_t a, logic [ElemW-1:0] b);
    return LoW'(a) * LoW'($signed({1'b0, b}));
  endfunction

  function automatic divst_t div_load(job_t j);
    divst_t s;
    s.sing = j.sing;
    s.ad   = j.ad;
    s.neg  = j.neg;
    s.ovf  = j.ovf;
    for (int i = 0; i < Lanes; i++) begin
      s.rem[i] = AdW'(j.m[i]);
      s.q[i]   = '0;
    end
    return s;
  endfunction

  // one restoring quotient bit per lane
  function automatic divst_t div_step(divst_t s);
    divst_t     n;
    logic [AdW:0] t;
    n = s;
    for (int i = 0; i < Lanes; i++) begin
      t = {s.rem[i], 1'b0};
      if (t >= {1'b0, s.ad}) begin
        n.rem[i] = AdW'(t - {1'b0, s.ad});
        n.q[i]   = {s.q[i][QW-2:0], 1'b1};
      end else begin
        n.rem[i] = t[AdW-1:0];
        n.q[i]   = {s.q[i][QW-2:0], 1'b0};
      end
    end
    return n;
  endfunction

  function automatic res_t div_finish(divst_t s);
    res_t             r;
    logic [ElemW-1:0] v;
    logic             clip;
    r.sing = s.sing;
    r.sat  = 1'b0;
    for (int i = 0; i < Lanes; i++) begin
      clip = 1'b0;
      if (s.ovf[i]) begin
        clip = 1'b1;
        v    = s.neg[i] ? NegMin : PosMax;
      end else if (!s.neg[i]) begin
        if (s.q[i] > PosMax) begin
          clip = 1'b1;
          v    = PosMax;
        end else begin
          v = s.q[i];
        end
      end else begin
        if (s.q[i] > NegMin) begin
          clip = 1'b1;
          v    = NegMin;
        end else begin
          v = ~s.q[i] + 1'b1;
        end
      end
      if (s.sing) begin
        clip = 1'b0;
        v    = '0;
      end
      r.elem[i] = v;
      r.sat     = r.sat | clip;
    end
    return r;
  endfunction

endpackage

@@ sv/mi3_front.sv @@
module mi3_front (
  input  logic                                            clk,
  input  logic                                            rst,
  input  logic                                            push,
  output logic                                            full,
  input  logic [mi3_pkg::Lanes-1:0][mi3_pkg::ElemW-1:0]   elem,
  output logic                                            job_valid,
  output mi3_pkg::job_t                                   job,
  input  logic                                            job_full
);
  import mi3_pkg::*;

  logic [5:0] vld;
  logic       adv;

  elem_t a0   [Lanes];
  prod_t pa1  [Lanes];
  prod_t pb1  [Lanes];
  elem_t col1 [3];
  prod_t cof2 [Lanes];
  elem_t col2 [3];
  prod_t cof3 [Lanes];
  plo_t  lo3  [3];
  prod_t hi3  [3];
  prod_t cof4 [Lanes];
  det_t  det4;

  prod_t pa [Lanes];
  prod_t pb [Lanes];
  det_t  det_sum;
  det_t  det_abs;
  logic  det_neg;
  job_t  job_next;

  assign adv       = !vld[5] || !job_full;
  assign full      = !adv;
  assign job_valid = vld[5];

  // a[r][c] sits at index c*3+r
  for (genvar r = 0; r < 3; r++) begin : g_row
    for (genvar c = 0; c < 3; c++) begin : g_col
      localparam int R1 = (r + 1) % 3;
      localparam int R2 = (r + 2) % 3;
      localparam int C1 = (c + 1) % 3;
      localparam int C2 = (c + 2) % 3;
      assign pa[r*3+c] = mul_ss(a0[C1*3+R1], a0[C2*3+R2]);
      assign pb[r*3+c] = mul_ss(a0[C2*3+R1], a0[C1*3+R2]);
    end
  end

  always_comb begin
    det_sum = '0;
    for (int r = 0; r < 3; r++) begin
      det_sum = det_sum + (DetW'(hi3[r]) <<< ShiftW) + DetW'(lo3[r]);
    end
  end

  // lane c*3+r takes cof[c][r], which is cof4[c*3+r]
  always_comb begin
    det_neg       = det4[DetW-1];
    det_abs       = det_neg ? -det4 : det4;
    job_next.sing = (det4 == '0);
    job_next.ad   = det_abs[AdW-1:0];
    for (int i = 0; i < Lanes; i++) begin
      job_next.m[i]   = cof4[i][ProdW-1] ? ProdW'(-cof4[i]) : ProdW'(cof4[i]);
      job_next.neg[i] = (cof4[i][ProdW-1] != det_neg) && (cof4[i] != '0);
      job_next.ovf[i] = AdW'(job_next.m[i]) >= det_abs[AdW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[4:0], push};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < Lanes; i++) begin
        a0[i]   <= elem_t'(elem[i]);
        pa1[i]  <= pa[i];
        pb1[i]  <= pb[i];
        cof2[i] <= pa1[i] - pb1[i];
        cof3[i] <= cof2[i];
        cof4[i] <= cof3[i];
      end
      for (int r = 0; r < 3; r++) begin
        col1[r] <= a0[r];
        col2[r] <= col1[r];
        lo3[r]  <= mul_lo(col2[r], cof2[r*3][ElemW-1:0]);
        hi3[r]  <= mul_ss(col2[r], elem_t'(cof2[r*3][ProdW-1:ElemW]));
      end
      det4 <= det_sum;
      job  <= job_next;
    end
  end

endmodule

@@ sv/mi3_queue.sv @@
module mi3_queue #(
  parameter int Depth = 4
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  output logic          full,
  input  mi3_pkg::job_t wdata,
  input  logic          pop,
  output logic          empty,
  output mi3_pkg::job_t rdata
);
  import mi3_pkg::*;

  localparam int AW = $clog2(Depth);
  localparam int CW = $clog2(Depth + 1);

  job_t          mem [Depth];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign full    = (count == CW'(Depth));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(Depth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(Depth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

endmodule

@@ sv/mi3_back.sv @@
module mi3_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          job_valid,
  input  mi3_pkg::job_t job,
  output logic          job_pop,
  output logic          empty,
  input  logic          pop,
  output mi3_pkg::res_t res
);
  import mi3_pkg::*;

  divst_t     st [QW+1];
  logic [QW:0] sv;
  logic       ovld;
  logic       adv;

  assign adv     = !ovld || pop;
  assign job_pop = adv && job_valid;
  assign empty   = !ovld;

  always_ff @(posedge clk) begin
    if (rst) begin
      sv   <= '0;
      ovld <= 1'b0;
    end else if (adv) begin
      sv   <= {sv[QW-1:0], job_valid};
      ovld <= sv[QW];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      st[0] <= div_load(job);
      for (int k = 1; k <= QW; k++) begin
        st[k] <= div_step(st[k-1]);
      end
      res <= div_finish(st[QW]);
    end
  end

  a_sing_no_sat: assert property (@(posedge clk) disable iff (rst)
    ovld && res.sing |-> !res.sat)
    else $error("singular result flagged saturated");

  a_sing_zero: assert property (@(posedge clk) disable iff (rst)
    ovld && res.sing |-> res.elem == '0)
    else $error("singular result has nonzero elements");

  a_drain: assert property (@(posedge clk) disable iff (rst)
    sv[QW] && !ovld |=> ovld)
    else $error("finished word not moved to output register");

endmodule

@@ sv/matrix_inverse_3x3.sv @@
// channel   direction  handshake         word
// input     in         push / full       in_c0_r0 .. in_c2_r2
// result    out        pop / empty       out_c0_r0 .. out_c2_r2, singular, saturated
//
// One matrix per cycle sustained while the result channel is popped every cycle.
// Latency is set by the 32 stage quotient pipeline (one bit per stage, nine lanes).
// Front (6 stages) and back stall independently; a QDepth entry queue sits between.
// rst is synchronous and clears all valid state.
module matrix_inverse_3x3 #(
  parameter int QDepth = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [31:0] in_c0_r0,
  input  logic [31:0] in_c0_r1,
  input  logic [31:0] in_c0_r2,
  input  logic [31:0] in_c1_r0,
  input  logic [31:0] in_c1_r1,
  input  logic [31:0] in_c1_r2,
  input  logic [31:0] in_c2_r0,
  input  logic [31:0] in_c2_r1,
  input  logic [31:0] in_c2_r2,
  output logic        empty,
  input  logic        pop,
  output logic [31:0] out_c0_r0,
  output logic [31:0] out_c0_r1,
  output logic [31:0] out_c0_r2,
  output logic [31:0] out_c1_r0,
  output logic [31:0] out_c1_r1,
  output logic [31:0] out_c1_r2,
  output logic [31:0] out_c2_r0,
  output logic [31:0] out_c2_r1,
  output logic [31:0] out_c2_r2,
  output logic        singular,
  output logic        saturated
);
  import mi3_pkg::*;

  logic [Lanes-1:0][ElemW-1:0] elem;
  job_t fr_job;
  job_t bk_job;
  logic fr_valid;
  logic q_full;
  logic q_empty;
  logic bk_pop;
  res_t res;

  assign elem = {in_c2_r2, in_c2_r1, in_c2_r0,
                 in_c1_r2, in_c1_r1, in_c1_r0,
                 in_c0_r2, in_c0_r1, in_c0_r0};

  mi3_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .elem      (elem),
    .job_valid (fr_valid),
    .job       (fr_job),
    .job_full  (q_full)
  );

  mi3_queue #(.Depth(QDepth)) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (fr_valid),
    .full  (q_full),
    .wdata (fr_job),
    .pop   (bk_pop),
    .empty (q_empty),
    .rdata (bk_job)
  );

  mi3_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (!q_empty),
    .job       (bk_job),
    .job_pop   (bk_pop),
    .empty     (empty),
    .pop       (pop),
    .res       (res)
  );

  assign out_c0_r0 = res.elem[0];
  assign out_c0_r1 = res.elem[1];
  assign out_c0_r2 = res.elem[2];
  assign out_c1_r0 = res.elem[3];
  assign out_c1_r1 = res.elem[4];
  assign out_c1_r2 = res.elem[5];
  assign out_c2_r0 = res.elem[6];
  assign out_c2_r1 = res.elem[7];
  assign out_c2_r2 = res.elem[8];
  assign singular  = res.sing;
  assign saturated = res.sat;

endmodule

@@ tb/matrix_inverse_3x3_tb.sv @@
`timescale 1ns / 1ps

module matrix_inverse_3x3_tb;

  typedef struct packed {
    logic [8:0][31:0] el;
    logic             sing;
    logic             sat;
  } inv_word_t;

  typedef struct packed {
    logic      use_lit;
    inv_word_t lit;
  } pend_t;

  localparam int unsigned NumRandom = 1030;
  localparam int unsigned CycleLimit = 400000;
  localparam logic [31:0] One = 32'h0001_0000;

  logic clk;
  logic rst;
  logic push;
  logic pop;
  logic full;
  logic empty;
  logic [8:0][31:0] din;
  logic [8:0][31:0] dout;
  logic singular;
  logic saturated;

  inv_word_t inverse_q[$];
  pend_t     pend_q[$];
  int unsigned errors;
  int unsigned cycles;

  matrix_inverse_3x3 DUT (
    .clk(clk), .rst(rst), .push(push), .full(full),
    .in_c0_r0(din[0]), .in_c0_r1(din[1]), .in_c0_r2(din[2]),
    .in_c1_r0(din[3]), .in_c1_r1(din[4]), .in_c1_r2(din[5]),
    .in_c2_r0(din[6]), .in_c2_r1(din[7]), .in_c2_r2(din[8]),
    .empty(empty), .pop(pop),
    .out_c0_r0(dout[0]), .out_c0_r1(dout[1]), .out_c0_r2(dout[2]),
    .out_c1_r0(dout[3]), .out_c1_r1(dout[4]), .out_c1_r2(dout[5]),
    .out_c2_r0(dout[6]), .out_c2_r1(dout[7]), .out_c2_r2(dout[8]),
    .singular(singular), .saturated(saturated)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic inv_word_t predict_inverse(logic [8:0][31:0] m);
    logic signed [63:0]  a [3][3];
    logic signed [63:0]  cof [3][3];
    logic signed [127:0] det;
    logic signed [127:0] x;
    logic signed [127:0] y;
    logic [127:0]        ad;
    logic [127:0]        num;
    logic [127:0]        q;
    logic [63:0]         mag;
    logic signed [63:0]  adj;
    logic                neg;
    inv_word_t           res;
    for (int c = 0; c < 3; c++)
      for (int r = 0; r < 3; r++)
        a[r][c] = 64'($signed(m[c*3+r]));
    for (int r = 0; r < 3; r++)
      for (int c = 0; c < 3; c++)
        cof[r][c] = a[(r+1)%3][(c+1)%3] * a[(r+2)%3][(c+2)%3]
                  - a[(r+1)%3][(c+2)%3] * a[(r+2)%3][(c+1)%3];
    det = '0;
    for (int r = 0; r < 3; r++) begin
      x = 128'(a[r][0]);
      y = 128'(cof[r][0]);
      det = det + x * y;
    end
    res = '0;
    if (det == 0) begin
      res.sing = 1'b1;
      return res;
    end
    ad = det < 0 ? -det : det;
    for (int c = 0; c < 3; c++) begin
      for (int r = 0; r < 3; r++) begin
        adj = cof[c][r];
        neg = (adj < 0) != (det < 0);
        if (adj == 0) neg = 1'b0;
        mag = adj < 0 ? -adj : adj;
        num = {32'b0, mag, 32'b0};
        q = num / ad;
        if (!neg) begin
          if (q > 128'h7FFF_FFFF) begin
            res.el[c*3+r] = 32'h7FFF_FFFF;
            res.sat = 1'b1;
          end else begin
            res.el[c*3+r] = q[31:0];
          end
        end else begin
          if (q > 128'h8000_0000) begin
            res.el[c*3+r] = 32'h8000_0000;
            res.sat = 1'b1;
          end else begin
            res.el[c*3+r] = -q[31:0];
          end
        end
      end
    end
    return res;
  endfunction

  function automatic logic [8:0][31:0] diag(logic [31:0] v);
    logic [8:0][31:0] m;
    m = '0;
    m[0] = v;
    m[4] = v;
    m[8] = v;
    return m;
  endfunction

  function automatic inv_word_t diag_word(logic [31:0] v, logic sat);
    inv_word_t w;
    w = '0;
    w.el = diag(v);
    w.sat = sat;
    return w;
  endfunction

  function automatic logic [31:0] small_elem();
    return $urandom_range(0, 1) ? $urandom_range(0, 32'h0004_0000)
                                : -$urandom_range(0, 32'h0004_0000);
  endfunction

  function automatic logic [8:0][31:0] random_matrix();
    logic [8:0][31:0] m;
    int               kind;
    int               k;
    kind = $urandom_range(0, 9);
    for (int i = 0; i < 9; i++) m[i] = small_elem();
    case (kind)
      0, 1: begin
        for (int i = 0; i < 9; i++) m[i] = $urandom;
      end
      2: begin
        k = $urandom_range(0, 2);
        for (int r = 0; r < 3; r++) m[((k+1)%3)*3+r] = m[k*3+r];
      end
      3: begin
        for (int i = 0; i < 9; i++) m[i] = $urandom_range(0, 1) ? $urandom_range(0, 3)
                                                               : -$urandom_range(0, 3);
      end
      4: begin
        for (int i = 0; i < 9; i++) begin
          k = $urandom_range(0, 3);
          m[i] = k == 0 ? 32'h7FFF_FFFF : k == 1 ? 32'h8000_0000 : k == 2 ? '0 : $urandom;
        end
      end
      5: begin
        m[0] = m[0] + One * 8;
        m[4] = m[4] + One * 8;
        m[8] = m[8] + One * 8;
      end
      default: ;
    endcase
    return m;
  endfunction

  task automatic report_mismatch(string what, int idx, logic [31:0] got, logic [31:0] want);
    errors++;
    $display("mismatch %s[%0d]: got %h expected %h at cycle %0d", what, idx, got, want, cycles);
  endtask

  always @(posedge clk) begin
    pend_t     p;
    inv_word_t w;
    if (!rst && push && !full) begin
      p = pend_q.pop_front();
      inverse_q.push_back(p.use_lit ? p.lit : predict_inverse(din));
    end
    if (!rst && pop && !empty) begin
      if (inverse_q.size() == 0) begin
        report_mismatch("unexpected word", 0, dout[0], '0);
      end else begin
        w = inverse_q.pop_front();
        for (int i = 0; i < 9; i++)
          if (dout[i] !== w.el[i]) report_mismatch("out", i, dout[i], w.el[i]);
        if (singular !== w.sing)
          report_mismatch("singular", 0, 32'(singular), 32'(w.sing));
        if (saturated !== w.sat)
          report_mismatch("saturated", 0, 32'(saturated), 32'(w.sat));
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // receiver stall pattern, mode redrawn at random from four modes
  int unsigned pop_mode;
  int unsigned pop_cnt;
  always @(negedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      pop_cnt++;
      if (pop_cnt % 64 == 0) pop_mode = $urandom_range(0, 3);
      case (pop_mode)
        0: pop <= 1'b1;
        1: pop <= 1'($urandom_range(0, 1));
        2: pop <= (pop_cnt % 32) >= 20;
        default: pop <= $urandom_range(0, 3) == 0;
      endcase
    end
  end

  task automatic send_matrix(logic [8:0][31:0] m, logic use_lit, inv_word_t lit);
    pend_t p;
    p.use_lit = use_lit;
    p.lit = lit;
    pend_q.push_back(p);
    push <= 1'b1;
    din <= m;
    do @(posedge clk); while (full);
    @(negedge clk);
  endtask

  task automatic idle_cycles(int unsigned n);
    logic [8:0][31:0] junk;
    for (int i = 0; i < 9; i++) junk[i] = $urandom;
    push <= 1'b0;
    din <= junk;
    repeat (n) @(negedge clk);
  endtask

  logic [8:0][31:0] dir_in [$];
  logic             dir_has [$];
  inv_word_t        dir_lit [$];

  task automatic add_row(logic [8:0][31:0] m, logic has, inv_word_t lit);
    dir_in.push_back(m);
    dir_has.push_back(has);
    dir_lit.push_back(lit);
  endtask

  initial begin
    logic [8:0][31:0] m;
    inv_word_t        sing_word;
    int unsigned      burst;
    int unsigned      sent;
    errors = 0;
    cycles = 0;
    pop_mode = 0;
    pop_cnt = 0;
    rst = 1'b1;
    push = 1'b0;
    din = '0;
    sing_word = '0;
    sing_word.sing = 1'b1;

    add_row('0, 1'b1, sing_word);
    add_row(diag(One), 1'b1, diag_word(One, 1'b0));
    add_row(diag(-One), 1'b1, diag_word(-One, 1'b0));
    add_row(diag(One * 2), 1'b1, diag_word(32'h0000_8000, 1'b0));
    add_row(diag(32'h1), 1'b1, diag_word(32'h7FFF_FFFF, 1'b1));
    add_row(diag(32'hFFFF_FFFF), 1'b1, diag_word(32'h8000_0000, 1'b1));
    add_row({9{32'h7FFF_FFFF}}, 1'b1, sing_word);
    add_row({9{32'h8000_0000}}, 1'b1, sing_word);
    add_row({9{32'hFFFF_FFFF}}, 1'b1, sing_word);
    add_row(diag(32'h7FFF_FFFF), 1'b0, '0);
    add_row(diag(32'h8000_0000), 1'b0, '0);
    m = '0; m[1] = One; m[5] = One; m[6] = One;
    add_row(m, 1'b0, '0);
    m = diag(One); m[3] = 32'h7FFF_FFFF; m[7] = 32'h8000_0000;
    add_row(m, 1'b0, '0);
    m = {32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
         32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000};
    add_row(m, 1'b0, '0);
    m = diag(One * 3); m[2] = One; m[6] = -One;
    add_row(m, 1'b0, '0);
    add_row(diag(32'h0000_0100), 1'b0, '0);
    m = '0; m[0] = 32'h8000_0000; m[4] = 32'h8000_0000; m[8] = One;
    add_row(m, 1'b0, '0);
    for (int i = 0; i < 5; i++) add_row(random_matrix(), 1'b0, '0);

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    for (int i = 0; i < dir_in.size(); i++) send_matrix(dir_in[i], dir_has[i], dir_lit[i]);

    sent = 0;
    while (sent < NumRandom) begin
      burst = $urandom_range(1, 40);
      for (int i = 0; i < burst && sent < NumRandom; i++) begin
        send_matrix(random_matrix(), 1'b0, '0);
        sent++;
        if (sent == NumRandom / 2) begin
          idle_cycles(1);
          while (inverse_q.size() != 0 || pend_q.size() != 0) @(negedge clk);
        end
      end
      if ($urandom_range(0, 3) != 0) idle_cycles($urandom_range(1, 12));
    end
    idle_cycles(1);

    while (inverse_q.size() != 0) @(negedge clk);
    repeat (60) @(negedge clk);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

@@ files.f @@
sv/mi3_pkg.sv
sv/mi3_front.sv
sv/mi3_queue.sv
sv/mi3_back.sv
sv/matrix_inverse_3x3.sv
tb/matrix_inverse_3x3_tb.sv
